/* hw/rtl/pcs_pkg.sv */
// Shared types and constants of the priority counting semaphore.
package pcs_pkg;

	localparam int LEVELS      = 8;
	localparam int WAITER_BITS = 8;
	localparam int LVL_W       = $clog2(LEVELS);
	localparam int CNT_W       = 12;
	localparam int KIND_W      = 1;
	localparam int LEVEL_W     = 3;
	localparam int LIMIT_W     = 4;
	localparam int INIT_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic [WAITER_BITS-1:0]  WAITER_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT = 2'd1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;
	localparam logic [INIT_W-1:0]  INIT_RESET  = 8'd1;

	localparam logic [KIND_W-1:0] KIND_WAIT = 1'b0;
	localparam logic [KIND_W-1:0] KIND_POST = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

/* hw/rtl/priority_counting_semaphore_top.sv */
// Top level of the priority counting semaphore: controller plus datapath.
//
// channel   direction  handshake                 payload
// item      in         start & !busy             kind, level
// result    out        done (one-cycle strobe)   granted, queued, release_valid,
//                                                release_level, overflow
// config    in         cfg_we                    cfg_idx, cfg_data
//
// Each item is taken at the capture edge, then runs in the execute state, in which
// the count update and the eight-level priority encode run; done pulses on the
// cycle after execute, and a new item may be accepted in that same cycle.
// The controller accepts no new item while busy is high in its execute state.
// Reset (arst_n low) loads levels_in_use=8, initial_count=1, count=1, waiters cleared.
// The result is not held: it is valid only in the cycle done is high.
module priority_counting_semaphore_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pcs_pkg::KIND_W-1:0]      kind,
	input  logic [pcs_pkg::LEVEL_W-1:0]     level,
	output logic                            done,
	output logic                            granted,
	output logic                            queued,
	output logic                            release_valid,
	output logic [pcs_pkg::LEVEL_W-1:0]     release_level,
	output logic                            overflow,
	input  logic                            cfg_we,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pcs_pkg::cmd_t cmd;

	// controller: idle / execute sequencing, drives busy
	pcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: semaphore state and result registers
	pcs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.level         (level),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.done          (done),
		.granted       (granted),
		.queued        (queued),
		.release_valid (release_valid),
		.release_level (release_level),
		.overflow      (overflow)
	);

	// busy is always low again in the cycle after it is high
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// a result follows only an execute cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a preceding execute");

	// exactly one outcome flag per wait; at most release for a post
	a_outcome_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({granted, queued, release_valid, overflow}))
		else $error("more than one outcome flag");

	// release level is zero when nothing is released
	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !release_valid) |-> (release_level == '0))
		else $error("release_level set without release");

endmodule

/* hw/rtl/pcs_ctrl.sv */
// Controller state machine: accepts an item and sequences its execution.
module pcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output pcs_pkg::cmd_t  cmd
);

	pcs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = pcs_pkg::ST_EXEC;
				end
			end
			pcs_pkg::ST_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
				state_d     = pcs_pkg::ST_IDLE;
			end
			default: begin
				state_d = pcs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/pcs_dp.sv */
// Datapath: count, per-level waiter counters, release priority encoder, result registers.
module pcs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcs_pkg::cmd_t                     cmd,
	input  logic [pcs_pkg::KIND_W-1:0]        kind,
	input  logic [pcs_pkg::LEVEL_W-1:0]       level,
	input  logic                              cfg_we,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              done,
	output logic                              granted,
	output logic                              queued,
	output logic                              release_valid,
	output logic [pcs_pkg::LEVEL_W-1:0]       release_level,
	output logic                              overflow
);

	logic [pcs_pkg::LIMIT_W-1:0]            limit_q;
	logic signed [pcs_pkg::CNT_W-1:0]       count_q;
	logic [pcs_pkg::WAITER_BITS-1:0]        waiters_q [pcs_pkg::LEVELS];
	logic [pcs_pkg::KIND_W-1:0]             kind_q;
	logic [pcs_pkg::LVL_W-1:0]              level_q;
	logic                                   done_q;
	logic                                   granted_q, queued_q, rel_valid_q, overflow_q;
	logic [pcs_pkg::LVL_W-1:0]              rel_level_q;

	logic [pcs_pkg::LVL_W-1:0]  level_clamped;
	logic [pcs_pkg::LVL_W:0]    scan_lim;
	logic                       found;
	logic [pcs_pkg::LVL_W-1:0]  found_idx;
	logic                       do_grant, do_queue, do_ovf, do_post, do_release;

	// out-of-range level maps to the top level
	always_comb begin
		if (int'(level) >= pcs_pkg::LEVELS) begin
			level_clamped = pcs_pkg::LVL_W'(pcs_pkg::LEVELS - 1);
		end else begin
			level_clamped = pcs_pkg::LVL_W'(level);
		end
	end

	// number of levels scanned, clamped to 1..LEVELS
	always_comb begin
		if (limit_q == '0) begin
			scan_lim = (pcs_pkg::LVL_W+1)'(1);
		end else if (int'(limit_q) > pcs_pkg::LEVELS) begin
			scan_lim = (pcs_pkg::LVL_W+1)'(pcs_pkg::LEVELS);
		end else begin
			scan_lim = (pcs_pkg::LVL_W+1)'(limit_q);
		end
	end

	// highest nonempty level below the limit wins
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = 0; i < pcs_pkg::LEVELS; i++) begin
			if ((waiters_q[i] != '0) && ((pcs_pkg::LVL_W+1)'(i) < scan_lim)) begin
				found     = 1'b1;
				found_idx = pcs_pkg::LVL_W'(i);
			end
		end
	end

	always_comb begin
		do_grant   = 1'b0;
		do_queue   = 1'b0;
		do_ovf     = 1'b0;
		do_post    = 1'b0;
		do_release = 1'b0;
		if (kind_q == pcs_pkg::KIND_WAIT) begin
			priority if (count_q > 0) begin
				do_grant = 1'b1;
			end else if ((count_q == pcs_pkg::CNT_MIN) ||
			             (waiters_q[level_q] == pcs_pkg::WAITER_MAX)) begin
				do_ovf = 1'b1;
			end else begin
				do_queue = 1'b1;
			end
		end else if (count_q != pcs_pkg::CNT_MAX) begin
			do_post    = 1'b1;
			do_release = (count_q < 0) && found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pcs_pkg::LIMIT_RESET;
			count_q <= $signed(pcs_pkg::CNT_W'(pcs_pkg::INIT_RESET));
			for (int i = 0; i < pcs_pkg::LEVELS; i++) begin
				waiters_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cfg_we && (cfg_idx == pcs_pkg::REG_LEVELS_IN_USE)) begin
				limit_q <= pcs_pkg::LIMIT_W'(cfg_data);
			end
			if (cfg_we && (cfg_idx == pcs_pkg::REG_INITIAL_COUNT)) begin
				count_q <= $signed(pcs_pkg::CNT_W'(pcs_pkg::INIT_W'(cfg_data)));
				for (int i = 0; i < pcs_pkg::LEVELS; i++) begin
					waiters_q[i] <= '0;
				end
			end else if (cmd.execute) begin
				if (do_grant || do_queue) begin
					count_q <= count_q - pcs_pkg::CNT_W'(1);
				end
				if (do_post) begin
					count_q <= count_q + pcs_pkg::CNT_W'(1);
				end
				if (do_queue) begin
					waiters_q[level_q] <= waiters_q[level_q] + pcs_pkg::WAITER_BITS'(1);
				end
				if (do_release) begin
					waiters_q[found_idx] <= waiters_q[found_idx] - pcs_pkg::WAITER_BITS'(1);
				end
			end
		end
	end

	// item and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			level_q <= level_clamped;
		end
		if (cmd.execute) begin
			granted_q   <= do_grant;
			queued_q    <= do_queue;
			overflow_q  <= do_ovf;
			rel_valid_q <= do_release;
			rel_level_q <= do_release ? found_idx : '0;
		end
	end

	assign done          = done_q;
	assign granted       = granted_q;
	assign queued        = queued_q;
	assign overflow      = overflow_q;
	assign release_valid = rel_valid_q;
	assign release_level = pcs_pkg::LEVEL_W'(rel_level_q);

endmodule

/* sim/priority_counting_semaphore_top_tb.sv */
// Self-checking testbench for the priority counting semaphore: directed, corner and random items.
module priority_counting_semaphore_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Register slots with nothing behind them; writes there must be ignored.
	localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int SETTLE       = 3;     // quiet cycles before a register write
	localparam int RANDOM_ITEMS = 950;
	// Two waits past a full waiter counter at one level.
	localparam int FILL_WAITS   = int'(pcs_pkg::WAITER_MAX) + 2;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_CFG,
		OP_DRAIN
	} pend_op_t;

	typedef struct {
		pend_op_t                         op;
		logic [pcs_pkg::KIND_W-1:0]       kind;
		logic [pcs_pkg::LEVEL_W-1:0]      level;
		int                               gap;      // idle cycles after this item is taken
		logic [pcs_pkg::CFG_IDX_W-1:0]    idx;
		logic [pcs_pkg::CFG_DATA_W-1:0]   data;
	} pending_t;

	typedef struct packed {
		logic                          granted;
		logic                          queued;
		logic                          release_valid;
		logic [pcs_pkg::LEVEL_W-1:0]   release_level;
		logic                          overflow;
	} outcome_t;

	// DUT ports; every input holds a known value from time zero.
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic [pcs_pkg::KIND_W-1:0]       kind = pcs_pkg::KIND_WAIT;
	logic [pcs_pkg::LEVEL_W-1:0]      level = '0;
	logic                             done;
	logic                             granted;
	logic                             queued;
	logic                             release_valid;
	logic [pcs_pkg::LEVEL_W-1:0]      release_level;
	logic                             overflow;
	logic                             cfg_we = 1'b0;
	logic [pcs_pkg::CFG_IDX_W-1:0]    cfg_idx = '0;
	logic [pcs_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

	// Shadow copy of the semaphore: registers, count and waiter counters.
	logic [pcs_pkg::LIMIT_W-1:0]        sem_limit;
	logic [pcs_pkg::INIT_W-1:0]         sem_init;
	logic signed [pcs_pkg::CNT_W-1:0]   sem_count;
	logic [pcs_pkg::WAITER_BITS-1:0]    sem_waiters [pcs_pkg::LEVELS];

	pending_t  pending_q[$];
	outcome_t  predicted_q[$];

	int errors = 0;
	int issued = 0;          // items taken by the DUT (driver only)
	int cfg_writes = 0;
	int results_seen = 0;    // results taken (monitor only, nonblocking)
	int n_granted = 0, n_queued = 0, n_released = 0, n_refused = 0;

	// Driver scratch
	pending_t  nxt;
	int        gap_left, quiet, outstanding;
	logic      drive_start, drive_we;

	// Monitor scratch
	outcome_t  seen, want;

	priority_counting_semaphore_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.level         (level),
		.done          (done),
		.granted       (granted),
		.queued        (queued),
		.release_valid (release_valid),
		.release_level (release_level),
		.overflow      (overflow),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	// Load the count from initial_count and forget every waiter.
	function automatic void reload_count();
		sem_count = signed'({{(pcs_pkg::CNT_W-pcs_pkg::INIT_W){1'b0}}, sem_init});
		foreach (sem_waiters[i])
			sem_waiters[i] = '0;
	endfunction

	function automatic void apply_config(input logic [pcs_pkg::CFG_IDX_W-1:0] idx,
			input logic [pcs_pkg::CFG_DATA_W-1:0] data);
		unique case (idx)
			pcs_pkg::REG_LEVELS_IN_USE: sem_limit = data[pcs_pkg::LIMIT_W-1:0];
			pcs_pkg::REG_INITIAL_COUNT: begin
				sem_init = data[pcs_pkg::INIT_W-1:0];
				reload_count();
			end
			default: ;
		endcase
	endfunction

	// Advance the shadow state by one item and return what the DUT must report.
	function automatic outcome_t predict_outcome(input logic [pcs_pkg::KIND_W-1:0] k,
			input logic [pcs_pkg::LEVEL_W-1:0] lv);
		outcome_t o;
		int slot;
		int scan;
		o = '0;
		// Levels past the top fold onto the top level (no-op at eight levels).
		slot = int'(lv);
		if (slot >= pcs_pkg::LEVELS)
			slot = pcs_pkg::LEVELS - 1;
		if (k == pcs_pkg::KIND_WAIT) begin
			if (sem_count > 0) begin
				sem_count = sem_count - pcs_pkg::CNT_W'(1);
				o.granted = 1'b1;
			end else if (sem_count == pcs_pkg::CNT_MIN ||
					sem_waiters[slot] == pcs_pkg::WAITER_MAX) begin
				// refused: nothing changes
				o.overflow = 1'b1;
			end else begin
				sem_count = sem_count - pcs_pkg::CNT_W'(1);
				sem_waiters[slot] = sem_waiters[slot] + 1'b1;
				o.queued = 1'b1;
			end
		end else if (sem_count != pcs_pkg::CNT_MAX) begin
			sem_count = sem_count + pcs_pkg::CNT_W'(1);
			if (sem_count <= 0) begin
				// levels_in_use clamps to 1..LEVELS; highest waiting level wins
				scan = int'(sem_limit);
				if (scan < 1)
					scan = 1;
				if (scan > pcs_pkg::LEVELS)
					scan = pcs_pkg::LEVELS;
				for (int i = scan - 1; i >= 0; i--) begin
					if (!o.release_valid && sem_waiters[i] != '0) begin
						sem_waiters[i] = sem_waiters[i] - 1'b1;
						o.release_valid = 1'b1;
						o.release_level = pcs_pkg::LEVEL_W'(i);
					end
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("MISMATCH at %0t: %s: got %0d, want %0d", $realtime, what, got, exp_val);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly back to back or short gaps, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_item(input logic [pcs_pkg::KIND_W-1:0] k,
			input logic [pcs_pkg::LEVEL_W-1:0] lv, input int gap);
		pending_t p;
		p = '{op: OP_ITEM, kind: k, level: lv, gap: gap, idx: '0, data: '0};
		pending_q.push_back(p);
	endtask

	task automatic add_cfg(input logic [pcs_pkg::CFG_IDX_W-1:0] idx,
			input logic [pcs_pkg::CFG_DATA_W-1:0] data);
		pending_t p;
		p = '{op: OP_CFG, kind: pcs_pkg::KIND_WAIT, level: '0, gap: 0, idx: idx, data: data};
		pending_q.push_back(p);
	endtask

	// Hold the sender until every predicted result has come back.
	task automatic add_drain();
		pending_t p;
		p = '{op: OP_DRAIN, kind: pcs_pkg::KIND_WAIT, level: '0, gap: 0, idx: '0, data: '0};
		pending_q.push_back(p);
	endtask

	// A run of items; wait_pct steers the count up or down, focus >= 0 piles
	// most waits onto one level.
	task automatic add_block(input int n, input int wait_pct, input bit burst, input int focus);
		logic [pcs_pkg::KIND_W-1:0]  k;
		logic [pcs_pkg::LEVEL_W-1:0] lv;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 99) < wait_pct) ? pcs_pkg::KIND_WAIT : pcs_pkg::KIND_POST;
			if (focus >= 0 && $urandom_range(0, 3) != 0)
				lv = pcs_pkg::LEVEL_W'(focus);
			else
				lv = pcs_pkg::LEVEL_W'($urandom);
			add_item(k, lv, burst ? 0 : pick_gap());
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued items, holds start through busy, and writes
	// registers only once the DUT has gone quiet.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			gap_left = 0;
			quiet = 0;
		end else begin
			if (start && !busy) begin
				predicted_q.push_back(predict_outcome(kind, level));
				issued++;
			end
			outstanding = issued - results_seen;
			if (!start && outstanding == 0)
				quiet++;
			else
				quiet = 0;

			if (start && busy) begin
				// item still on offer; keep everything as it is
			end else begin
				drive_start = 1'b0;
				drive_we = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_q.size() > 0) begin
					nxt = pending_q[0];
					case (nxt.op)
						OP_ITEM: begin
							void'(pending_q.pop_front());
							kind <= nxt.kind;
							level <= nxt.level;
							drive_start = 1'b1;
							gap_left = nxt.gap;
						end
						OP_DRAIN: begin
							if (quiet >= SETTLE)
								void'(pending_q.pop_front());
						end
						OP_CFG: begin
							if (quiet >= SETTLE) begin
								void'(pending_q.pop_front());
								cfg_idx <= nxt.idx;
								cfg_data <= nxt.data;
								drive_we = 1'b1;
								apply_config(nxt.idx, nxt.data);
								cfg_writes++;
								quiet = 0;
							end
						end
						default: ;
					endcase
				end
				start <= drive_start;
				cfg_we <= drive_we;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every done strobe is one result, checked against the oldest
	// prediction.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done === 1'b1) begin
			seen = '{granted, queued, release_valid, release_level, overflow};
			if (predicted_q.size() == 0) begin
				report_mismatch("result with no item outstanding", 1, 0);
			end else begin
				want = predicted_q.pop_front();
				if (seen.granted !== want.granted)
					report_mismatch("granted", seen.granted, want.granted);
				if (seen.queued !== want.queued)
					report_mismatch("queued", seen.queued, want.queued);
				if (seen.release_valid !== want.release_valid)
					report_mismatch("release_valid", seen.release_valid, want.release_valid);
				if (seen.release_level !== want.release_level)
					report_mismatch("release_level", seen.release_level, want.release_level);
				if (seen.overflow !== want.overflow)
					report_mismatch("overflow", seen.overflow, want.overflow);
				n_granted += want.granted;
				n_queued += want.queued;
				n_released += want.release_valid;
				n_refused += want.overflow;
			end
			results_seen <= results_seen + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int rand_count;
		int pick;
		int n;
		int wait_pct;
		int focus;
		bit burst;
		logic [pcs_pkg::LEVEL_W-1:0] fill_lvl;

		// shadow state out of reset: eight levels, count of one
		sem_limit = pcs_pkg::LIMIT_RESET;
		sem_init = pcs_pkg::INIT_RESET;
		reload_count();

		// --- directed: grant, queue at several levels, priority release ---
		add_item(pcs_pkg::KIND_WAIT, 3'd0, 0);     // takes the one token
		add_item(pcs_pkg::KIND_WAIT, 3'd7, 0);     // top level blocks
		add_item(pcs_pkg::KIND_WAIT, 3'd0, 1);
		add_item(pcs_pkg::KIND_WAIT, 3'd5, 0);
		add_item(pcs_pkg::KIND_POST, 3'd3, 0);     // level field ignored; level 7 goes first
		add_item(pcs_pkg::KIND_POST, 3'd0, 2);     // then level 5
		// narrow the scan to level 0 only
		add_cfg(pcs_pkg::REG_LEVELS_IN_USE, 8'h01);
		add_item(pcs_pkg::KIND_WAIT, 3'd6, 0);
		add_item(pcs_pkg::KIND_POST, 3'd7, 0);     // level 0 waiter released
		add_item(pcs_pkg::KIND_POST, 3'd0, 0);     // only level 6 waits: count moves, nobody released
		add_item(pcs_pkg::KIND_POST, 3'd0, 0);
		// zero acts as one level
		add_cfg(pcs_pkg::REG_LEVELS_IN_USE, 8'h00);
		add_item(pcs_pkg::KIND_WAIT, 3'd2, 0);
		add_item(pcs_pkg::KIND_WAIT, 3'd2, 0);
		add_item(pcs_pkg::KIND_POST, 3'd1, 0);     // level 2 out of reach
		// 15 (upper data bits set) acts as all eight levels
		add_cfg(pcs_pkg::REG_LEVELS_IN_USE, 8'hFF);
		add_item(pcs_pkg::KIND_WAIT, 3'd1, 0);
		add_item(pcs_pkg::KIND_POST, 3'd0, 0);     // level 6 is the highest waiting
		add_item(pcs_pkg::KIND_POST, 3'd0, 0);
		// writes to unused slots change nothing
		add_cfg(REG_SPARE_2, 8'hA5);
		add_cfg(REG_SPARE_3, 8'h5A);
		// count of zero: every wait blocks right away; reload clears waiters
		add_cfg(pcs_pkg::REG_INITIAL_COUNT, 8'h00);
		add_item(pcs_pkg::KIND_WAIT, 3'd4, 0);
		add_item(pcs_pkg::KIND_WAIT, 3'd3, 0);
		add_item(pcs_pkg::KIND_POST, 3'd0, 0);
		add_cfg(pcs_pkg::REG_INITIAL_COUNT, 8'hFF);
		add_item(pcs_pkg::KIND_WAIT, 3'd7, 0);
		add_item(pcs_pkg::KIND_POST, 3'd7, 0);

		// --- one waiter counter run up to full, then refused ---
		fill_lvl = pcs_pkg::LEVEL_W'($urandom);
		add_cfg(pcs_pkg::REG_LEVELS_IN_USE, 8'h08);
		add_cfg(pcs_pkg::REG_INITIAL_COUNT, 8'h00);
		for (int i = 0; i < FILL_WAITS; i++)
			add_item(pcs_pkg::KIND_WAIT, fill_lvl, $urandom_range(0, 1));
		add_item(pcs_pkg::KIND_WAIT, fill_lvl ^ 3'd1, 0);   // other level still has room
		for (int i = 0; i < 4; i++)
			add_item(pcs_pkg::KIND_POST, pcs_pkg::LEVEL_W'($urandom), pick_gap());
		add_drain();
		add_cfg(pcs_pkg::REG_INITIAL_COUNT, 8'h02);

		// --- random: blocks of items between occasional register changes ---
		rand_count = 0;
		while (rand_count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1: add_cfg(pcs_pkg::REG_LEVELS_IN_USE, pcs_pkg::CFG_DATA_W'($urandom));
				2: begin
					case ($urandom_range(0, 3))
						0: add_cfg(pcs_pkg::REG_INITIAL_COUNT, 8'h00);
						1: add_cfg(pcs_pkg::REG_INITIAL_COUNT, 8'hFF);
						2: add_cfg(pcs_pkg::REG_INITIAL_COUNT,
							pcs_pkg::CFG_DATA_W'($urandom_range(0, 6)));
						default: add_cfg(pcs_pkg::REG_INITIAL_COUNT,
							pcs_pkg::CFG_DATA_W'($urandom));
					endcase
				end
				3: add_cfg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
						pcs_pkg::CFG_DATA_W'($urandom));
				4: add_drain();
				default: ;
			endcase
			n = $urandom_range(10, 60);
			wait_pct = $urandom_range(20, 80);
			burst = ($urandom_range(0, 4) == 0);
			focus = ($urandom_range(0, 2) == 0) ? $urandom_range(0, pcs_pkg::LEVELS - 1) : -1;
			add_block(n, wait_pct, burst, focus);
			rand_count += n;
		end

		// single reset at the start, held from time zero and released on a rising clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// everything sent and every result back, then a short tail
		do
			@(negedge clk);
		while (!(pending_q.size() == 0 && !start && issued == results_seen));
		repeat (6) @(negedge clk);

		if (predicted_q.size() != 0)
			report_mismatch("results never arrived", 0, predicted_q.size());

		$display("Covered %0d items and %0d register writes", issued, cfg_writes);
		$display("Outcomes: %0d granted, %0d queued, %0d released, %0d refused",
			n_granted, n_queued, n_released, n_refused);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("Timeout: %0d items taken, %0d results seen", issued, results_seen);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
